FILE: sv/kwm_pkg.sv
// Shared widths and types for the k-way sorted run merge block.
package kwm_pkg;

   localparam int CFG_W   = 4;
   localparam int RUN_W   = 3;
   localparam int VALUE_W = 32;

   typedef struct packed {
      logic                      done;
      logic                      found;
      logic [RUN_W-1:0]          run;
      logic signed [VALUE_W-1:0] value;
   } scan_result_type;

endpackage

FILE: sv/kwm_channels.sv
// Request, response and register-write channel interfaces for the run merge block.
interface kwm_req_if;
   logic                               valid;
   logic                               ready;
   logic [kwm_pkg::RUN_W-1:0]          run_index;
   logic signed [kwm_pkg::VALUE_W-1:0] head_value;
   logic                               run_ended;

   modport source (output valid, run_index, head_value, run_ended, input ready);
   modport sink (input valid, run_index, head_value, run_ended, output ready);
endinterface

interface kwm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [kwm_pkg::VALUE_W-1:0] min_value;
   logic                               min_valid;
   logic [kwm_pkg::RUN_W-1:0]          refill_run;
   logic                               merge_done;
   logic                               order_error;

   modport source (output valid, min_value, min_valid, refill_run, merge_done, order_error,
                   input ready);
   modport sink (input valid, min_value, min_valid, refill_run, merge_done, order_error,
                 output ready);
endinterface

interface kwm_csr_if;
   logic                      valid;
   logic                      ready;
   logic [kwm_pkg::CFG_W-1:0] runs_in_use;

   modport source (output valid, runs_in_use, input ready);
   modport sink (input valid, runs_in_use, output ready);
endinterface

FILE: sv/kwm_head_scan.sv
// Head memory with a single compare unit that scans the live heads for the minimum.
module kwm_head_scan #(
   parameter int RUN_COUNT = 8,
   parameter int IDX_W     = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [kwm_pkg::CFG_W-1:0]          count,
   input  logic [RUN_COUNT-1:0]               live,
   input  logic                               wr_en,
   input  logic [IDX_W-1:0]                   wr_addr,
   input  logic signed [kwm_pkg::VALUE_W-1:0] wr_data,
   output kwm_pkg::scan_result_type           result
);

   logic signed [kwm_pkg::VALUE_W-1:0] head_mem [RUN_COUNT];

   logic                               busy_ff, busy_in;
   logic [kwm_pkg::CFG_W-1:0]          sidx_ff, sidx_in;
   logic                               rd_valid_ff;
   logic                               rd_last_ff;
   logic [kwm_pkg::CFG_W-1:0]          rd_idx_ff;
   logic signed [kwm_pkg::VALUE_W-1:0] rd_data_ff;
   logic                               found_ff, found_in;
   logic [kwm_pkg::RUN_W-1:0]          best_run_ff, best_run_in;
   logic signed [kwm_pkg::VALUE_W-1:0] best_val_ff, best_val_in;
   logic                               done_ff;
   logic                               last_rd;
   logic                               take;

   assign last_rd = (sidx_ff == count - kwm_pkg::CFG_W'(1));
   assign take    = rd_valid_ff && live[IDX_W'(rd_idx_ff)]
                    && (!found_ff || (rd_data_ff < best_val_ff));

   always_comb begin
      busy_in     = busy_ff;
      sidx_in     = sidx_ff;
      found_in    = found_ff;
      best_run_in = best_run_ff;
      best_val_in = best_val_ff;
      if (start) begin
         busy_in  = 1'b1;
         sidx_in  = '0;
         found_in = 1'b0;
      end else begin
         if (busy_ff) begin
            if (last_rd) begin
               busy_in = 1'b0;
            end else begin
               sidx_in = sidx_ff + kwm_pkg::CFG_W'(1);
            end
         end
         if (take) begin
            found_in    = 1'b1;
            best_run_in = kwm_pkg::RUN_W'(rd_idx_ff);
            best_val_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         head_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rd_data_ff <= head_mem[IDX_W'(sidx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rd_valid_ff <= busy_ff && !start;
         rd_last_ff  <= busy_ff && !start && last_rd;
         done_ff     <= rd_valid_ff && rd_last_ff && !start;
         found_ff    <= found_in;
      end
      sidx_ff     <= sidx_in;
      rd_idx_ff   <= sidx_ff;
      best_run_ff <= best_run_in;
      best_val_ff <= best_val_in;
   end

   assign result.done  = done_ff;
   assign result.found = found_ff;
   assign result.run   = best_run_ff;
   assign result.value = best_val_ff;

endmodule

FILE: sv/k_way_sorted_run_merge_core.sv
// Top level of the k-way sorted run merge: request control, live flags and response register.
// Fill and out-of-order requests: response registered and presented in the cycle after the request is taken.
// Requests that trigger a minimum search: response registered once the search is done, after the
// one-entry-per-cycle scan of the n runs in use in the head memory through a single comparator.
// A new request is taken when no search runs, no register write is offered and the response slot is free or draining.
// Synchronous active-high reset: fill phase, no live heads, runs_in_use = 8.
module k_way_sorted_run_merge_core #(
   parameter int RUN_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   kwm_req_if.sink     req_bus,
   kwm_rsp_if.source   rsp_bus,
   kwm_csr_if.sink     csr_bus
);

   localparam int IDX_W = $clog2(RUN_COUNT);
   localparam logic [kwm_pkg::CFG_W-1:0] RUN_CAP =
      kwm_pkg::CFG_W'((RUN_COUNT > 15) ? 15 : RUN_COUNT);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef enum logic {
      PH_FILL,
      PH_MERGE
   } phase_type;

   state_type                          state_ff, state_in;
   phase_type                          phase_ff, phase_in;
   logic [kwm_pkg::CFG_W-1:0]          runs_ff, runs_in;
   logic [kwm_pkg::CFG_W-1:0]          fill_ff, fill_in;
   logic [kwm_pkg::RUN_W-1:0]          awaited_ff, awaited_in;
   logic [RUN_COUNT-1:0]               live_ff, live_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [kwm_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                               rsp_min_valid_ff, rsp_min_valid_in;
   logic [kwm_pkg::RUN_W-1:0]          rsp_run_ff, rsp_run_in;
   logic                               rsp_done_ff, rsp_done_in;
   logic                               rsp_error_ff, rsp_error_in;

   logic [kwm_pkg::CFG_W-1:0]          n_active;
   logic [kwm_pkg::CFG_W-1:0]          fill_next;
   logic                               csr_take;
   logic                               req_take;
   logic                               req_bad;
   logic                               rsp_load;
   logic                               scan_start;
   logic                               wr_en;
   kwm_pkg::scan_result_type           scan_res;

   assign n_active = (runs_ff == '0) ? kwm_pkg::CFG_W'(1)
                   : ((runs_ff > RUN_CAP) ? RUN_CAP : runs_ff);
   assign fill_next = fill_ff + kwm_pkg::CFG_W'(1);

   assign csr_bus.ready = (state_ff == ST_IDLE);
   assign req_bus.ready = (state_ff == ST_IDLE) && !csr_bus.valid
                          && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_take = csr_bus.valid && csr_bus.ready;
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bad  = (req_bus.run_index != awaited_ff)
                     || ({1'b0, req_bus.run_index} >= n_active);
   assign wr_en    = req_take && !req_bad && !req_bus.run_ended;

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      runs_in          = runs_ff;
      fill_in          = fill_ff;
      awaited_in       = awaited_ff;
      live_in          = live_ff;
      rsp_load         = 1'b0;
      scan_start       = 1'b0;
      rsp_value_in     = rsp_value_ff;
      rsp_min_valid_in = rsp_min_valid_ff;
      rsp_run_in       = rsp_run_ff;
      rsp_done_in      = rsp_done_ff;
      rsp_error_in     = rsp_error_ff;
      if (csr_take) begin
         runs_in    = csr_bus.runs_in_use;
         phase_in   = PH_FILL;
         fill_in    = '0;
         awaited_in = '0;
         live_in    = '0;
      end else if (req_take) begin
         if (req_bad) begin
            rsp_load         = 1'b1;
            rsp_value_in     = '0;
            rsp_min_valid_in = 1'b0;
            rsp_run_in       = awaited_ff;
            rsp_done_in      = 1'b0;
            rsp_error_in     = 1'b1;
         end else begin
            live_in[IDX_W'(req_bus.run_index)] = !req_bus.run_ended;
            if ((phase_ff == PH_FILL) && (fill_next < n_active)) begin
               fill_in          = fill_next;
               awaited_in       = kwm_pkg::RUN_W'(fill_next);
               rsp_load         = 1'b1;
               rsp_value_in     = '0;
               rsp_min_valid_in = 1'b0;
               rsp_run_in       = kwm_pkg::RUN_W'(fill_next);
               rsp_done_in      = 1'b0;
               rsp_error_in     = 1'b0;
            end else begin
               if (phase_ff == PH_FILL) begin
                  fill_in = fill_next;
               end
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
      end else if ((state_ff == ST_SCAN) && scan_res.done) begin
         state_in         = ST_IDLE;
         rsp_load         = 1'b1;
         rsp_error_in     = 1'b0;
         if (scan_res.found) begin
            phase_in         = PH_MERGE;
            awaited_in       = scan_res.run;
            rsp_value_in     = scan_res.value;
            rsp_min_valid_in = 1'b1;
            rsp_run_in       = scan_res.run;
            rsp_done_in      = 1'b0;
         end else begin
            phase_in         = PH_FILL;
            fill_in          = '0;
            awaited_in       = '0;
            live_in          = '0;
            rsp_value_in     = '0;
            rsp_min_valid_in = 1'b0;
            rsp_run_in       = '0;
            rsp_done_in      = 1'b1;
         end
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FILL;
         runs_ff      <= kwm_pkg::CFG_W'(8);
         fill_ff      <= '0;
         awaited_ff   <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         runs_ff      <= runs_in;
         fill_ff      <= fill_in;
         awaited_ff   <= awaited_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff     <= rsp_value_in;
      rsp_min_valid_ff <= rsp_min_valid_in;
      rsp_run_ff       <= rsp_run_in;
      rsp_done_ff      <= rsp_done_in;
      rsp_error_ff     <= rsp_error_in;
   end

   kwm_head_scan #(
      .RUN_COUNT (RUN_COUNT),
      .IDX_W     (IDX_W)
   ) u_head_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .count   (n_active),
      .live    (live_ff),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_bus.run_index)),
      .wr_data (req_bus.head_value),
      .result  (scan_res)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.min_value   = rsp_value_ff;
   assign rsp_bus.min_valid   = rsp_min_valid_ff;
   assign rsp_bus.refill_run  = rsp_run_ff;
   assign rsp_bus.merge_done  = rsp_done_ff;
   assign rsp_bus.order_error = rsp_error_ff;

`ifndef SYNTH
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == ST_SCAN))
      else $error("search result outside of a search");

   a_min_is_live: assert property (@(posedge clock) disable iff (reset)
      (scan_res.done && scan_res.found) |-> live_ff[IDX_W'(scan_res.run)])
      else $error("emitted minimum from a retired run");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && scan_res.done && !scan_res.found)
      |=> ((live_ff == '0) && (fill_ff == '0) && (phase_ff == PH_FILL)))
      else $error("merge end did not restart the fill");

   a_slot_free_at_search_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && scan_res.done) |-> !rsp_valid_ff)
      else $error("search finished with the response slot occupied");
`endif

endmodule

FILE: dv/merge_checker.sv
// Checker for the k-way run merge: predicts every response and compares it field by field.
`timescale 1ns / 1ps
module merge_checker #(
   parameter int RUN_COUNT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic end_check,
   kwm_req_if   req_bus,
   kwm_rsp_if   rsp_bus,
   kwm_csr_if   csr_bus,
   output int   fail_count
);
   import kwm_pkg::*;

   typedef enum logic [1:0] {PHASE_FILL, PHASE_MERGE} merge_phase_e;

   typedef struct packed {
      logic signed [VALUE_W-1:0] min_value;
      logic                      min_valid;
      logic [RUN_W-1:0]          refill_run;
      logic                      merge_done;
      logic                      order_error;
   } merge_output_t;

   logic signed [VALUE_W-1:0] head_value_q[RUN_COUNT];
   logic                      head_live_q[RUN_COUNT];
   logic [CFG_W-1:0]          fill_count;
   logic [CFG_W-1:0]          runs_cfg;
   logic [RUN_W-1:0]          awaited_run;
   merge_phase_e              phase;
   merge_output_t             pending_outputs[$];
   bit                        end_seen;

   function automatic int active_runs();
      int n;
      n = int'(runs_cfg);
      if (n == 0) n = 1;
      if (n > RUN_COUNT) n = RUN_COUNT;
      return n;
   endfunction

   function automatic void restart_merge();
      foreach (head_live_q[i]) head_live_q[i] = 1'b0;
      fill_count  = '0;
      awaited_run = '0;
      phase       = PHASE_FILL;
   endfunction

   function automatic merge_output_t next_merge_output(input logic [RUN_W-1:0] run,
                                                       input logic signed [VALUE_W-1:0] value,
                                                       input logic ended);
      merge_output_t out;
      int            n;
      int            best;
      out  = '0;
      n    = active_runs();
      best = -1;
      if (run != awaited_run || int'(run) >= n) begin
         out.refill_run  = awaited_run;
         out.order_error = 1'b1;
         return out;
      end
      if (ended) begin
         head_live_q[run] = 1'b0;
      end else begin
         head_value_q[run] = value;
         head_live_q[run]  = 1'b1;
      end
      if (phase == PHASE_FILL) begin
         fill_count = fill_count + 1'b1;
         if (int'(fill_count) < n) begin
            awaited_run    = fill_count[RUN_W-1:0];
            out.refill_run = awaited_run;
            return out;
         end
      end
      // ties go to the lowest run index
      for (int i = 0; i < n; i++) begin
         if (head_live_q[i] && (best < 0 || head_value_q[i] < head_value_q[best])) best = i;
      end
      if (best < 0) begin
         restart_merge();
         out.merge_done = 1'b1;
      end else begin
         phase          = PHASE_MERGE;
         awaited_run    = RUN_W'(best);
         out.min_value  = head_value_q[best];
         out.min_valid  = 1'b1;
         out.refill_run = awaited_run;
      end
      return out;
   endfunction

   task automatic compare_output(input merge_output_t want);
      if (rsp_bus.min_value !== want.min_value) begin
         $error("min_value: expected %0d, got %0d", want.min_value, rsp_bus.min_value);
         fail_count++;
      end
      if (rsp_bus.min_valid !== want.min_valid) begin
         $error("min_valid: expected %0d, got %0d", want.min_valid, rsp_bus.min_valid);
         fail_count++;
      end
      if (rsp_bus.refill_run !== want.refill_run) begin
         $error("refill_run: expected %0d, got %0d", want.refill_run, rsp_bus.refill_run);
         fail_count++;
      end
      if (rsp_bus.merge_done !== want.merge_done) begin
         $error("merge_done: expected %0d, got %0d", want.merge_done, rsp_bus.merge_done);
         fail_count++;
      end
      if (rsp_bus.order_error !== want.order_error) begin
         $error("order_error: expected %0d, got %0d", want.order_error, rsp_bus.order_error);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         runs_cfg = CFG_W'(8);
         restart_merge();
         pending_outputs.delete();
      end else begin
         // a response always belongs to an earlier request
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outputs.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               compare_output(pending_outputs.pop_front());
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            runs_cfg = csr_bus.runs_in_use;
            restart_merge();
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_outputs.push_back(next_merge_output(req_bus.run_index, req_bus.head_value,
                                                        req_bus.run_ended));
         end
      end
      if (end_check && !end_seen) begin
         end_seen = 1'b1;
         if (pending_outputs.size() != 0) begin
            $error("%0d responses never arrived", pending_outputs.size());
            fail_count += pending_outputs.size();
         end
      end
   end

endmodule

FILE: dv/testbench.sv
// Testbench top for the k-way run merge: request stimulus, response flow control and verdict.
`timescale 1ns / 1ps
module testbench;
   import kwm_pkg::*;

   localparam int RUNS        = 8;
   localparam int MAX_RUN_LEN = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_REQS = 800;
   localparam int HOLD_CYCLES = 300;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic clock;
   logic reset = 1'b1;
   logic end_check;
   int   fail_count;
   int   cycle_count = 0;
   int   req_count   = 0;
   int   rsp_count   = 0;
   int   items_sent  = 0;
   bit   gaps_on;
   bit   hold_off_req;

   logic signed [VALUE_W-1:0] run_vals[RUNS][MAX_RUN_LEN];
   int                        run_len[RUNS];
   int                        head_pos[RUNS];

   kwm_req_if req_bus ();
   kwm_rsp_if rsp_bus ();
   kwm_csr_if csr_bus ();

   k_way_sorted_run_merge_core #(.RUN_COUNT(RUNS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   merge_checker #(.RUN_COUNT(RUNS)) merge_check (
      .clock      (clock),
      .reset      (reset),
      .end_check  (end_check),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls, quiet stretches, one long hold-off on demand
   initial begin
      int stall;
      int left_in_mode;
      bit quiet;
      left_in_mode  = 0;
      quiet         = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (left_in_mode == 0) begin
            quiet        = ($urandom_range(0, 3) == 0);
            left_in_mode = $urandom_range(10, 40);
         end
         left_in_mode--;
         stall = quiet ? 0 : $urandom_range(0, 9);
         if (hold_off_req) begin
            stall        = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         rsp_count++;
         @(negedge clock);
      end
   end

   // leaves valid high after the handshake; the caller sends again or calls wait_idle
   task automatic send_req(input logic [RUN_W-1:0] run, input logic signed [VALUE_W-1:0] value,
                           input logic ended);
      int gap;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.run_index  <= run;
      req_bus.head_value <= value;
      req_bus.run_ended  <= ended;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      req_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (rsp_count != req_count) @(negedge clock);
   endtask

   task automatic write_runs(input logic [CFG_W-1:0] value);
      wait_idle();
      csr_bus.valid       <= 1'b1;
      csr_bus.runs_in_use <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // request from a run other than the awaited one
   task automatic maybe_noise(input logic [RUN_W-1:0] awaited, input int rate);
      if (rate > 0 && $urandom_range(0, rate - 1) == 0) begin
         send_req(awaited + RUN_W'($urandom_range(1, 7)), $urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic fill_runs(input int n, input int max_len);
      longint      v;
      int unsigned step_max;
      bit          scrambled;
      for (int r = 0; r < RUNS; r++) begin
         run_len[r] = (r < n) ? $urandom_range(0, max_len) : 0;
         case ($urandom_range(0, 3))
            0: v = VALUE_MIN;
            1: v = longint'(VALUE_MAX) - $urandom_range(0, 3);
            2: v = longint'($urandom_range(0, 4)) - 2;
            default: v = longint'($signed($urandom));
         endcase
         step_max  = $urandom_range(0, 1) ? 3 : 32'h0FFF_FFFF;
         scrambled = ($urandom_range(0, 7) == 0);
         for (int i = 0; i < run_len[r]; i++) begin
            run_vals[r][i] = scrambled ? $urandom : v[31:0];
            v = v + $urandom_range(0, step_max);
            if (v > VALUE_MAX) v = VALUE_MAX;
         end
      end
   endtask

   // fill, then refill whichever run holds the smallest head until all runs end
   task automatic play_merge(input int n, input int noise_rate, input int abort_at,
                             output bit aborted);
      int best;
      int start;
      aborted = 1'b0;
      start   = items_sent;
      for (int r = 0; r < n; r++) begin
         if (abort_at >= 0 && items_sent - start >= abort_at) begin
            aborted = 1'b1;
            return;
         end
         maybe_noise(RUN_W'(r), noise_rate);
         head_pos[r] = 0;
         if (run_len[r] > 0) begin
            send_req(RUN_W'(r), run_vals[r][0], 1'b0);
         end else begin
            send_req(RUN_W'(r), $urandom, 1'b1);
         end
         items_sent++;
      end
      forever begin
         best = -1;
         for (int r = 0; r < n; r++) begin
            if (head_pos[r] < run_len[r] &&
                (best < 0 || run_vals[r][head_pos[r]] < run_vals[best][head_pos[best]])) best = r;
         end
         if (best < 0) return;
         if (abort_at >= 0 && items_sent - start >= abort_at) begin
            aborted = 1'b1;
            return;
         end
         maybe_noise(RUN_W'(best), noise_rate);
         head_pos[best]++;
         if (head_pos[best] < run_len[best]) begin
            send_req(RUN_W'(best), run_vals[best][head_pos[best]], 1'b0);
         end else begin
            send_req(RUN_W'(best), $urandom, 1'b1);
         end
         items_sent++;
      end
   endtask

   initial begin
      int         eff_runs;
      int         sessions;
      int         abort_at;
      int         max_len;
      bit         aborted;
      logic [3:0] cfg;
      req_bus.valid       = 1'b0;
      req_bus.run_index   = '0;
      req_bus.head_value  = '0;
      req_bus.run_ended   = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.runs_in_use = '0;
      end_check           = 1'b0;
      hold_off_req        = 1'b0;
      gaps_on             = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, ties, empty runs, wrong-run requests, run count clamping
      run_len        = '{default: 0};
      run_vals[0][0] = VALUE_MIN;
      run_vals[0][1] = 32'sd5;
      run_len[0]     = 2;
      run_vals[1][0] = VALUE_MAX;
      run_len[1]     = 1;
      run_vals[3][0] = VALUE_MIN;
      run_len[3]     = 1;
      run_vals[4][0] = 32'sd5;
      run_len[4]     = 1;
      run_vals[6][0] = 32'sd0;
      run_len[6]     = 1;
      send_req(3'd3, 32'sd7, 1'b0);
      play_merge(RUNS, 0, -1, aborted);
      write_runs(4'd0);
      send_req(3'd1, VALUE_MAX, 1'b0);
      run_len = '{default: 0};
      play_merge(1, 0, -1, aborted);
      run_vals[0][0] = VALUE_MAX;
      run_vals[0][1] = VALUE_MAX;
      run_len[0]     = 2;
      play_merge(1, 0, -1, aborted);
      write_runs(4'd15);
      run_len = '{default: 0};
      play_merge(RUNS, 0, -1, aborted);

      // random merges, mostly well formed
      eff_runs   = RUNS;
      sessions   = 0;
      aborted    = 1'b0;
      items_sent = 0;
      while (items_sent < RANDOM_REQS) begin
         if (aborted || $urandom_range(0, 5) == 0) begin
            cfg = 4'($urandom_range(0, 15));
            write_runs(cfg);
            eff_runs = (cfg == 0) ? 1 : (cfg > RUNS) ? RUNS : int'(cfg);
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         if (sessions == 4) begin
            gaps_on      = 1'b0;
            hold_off_req = 1'b1;
         end
         max_len  = ($urandom_range(0, 9) == 0) ? MAX_RUN_LEN : 4;
         abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : -1;
         fill_runs(eff_runs, max_len);
         play_merge(eff_runs, 8, abort_at, aborted);
         sessions++;
      end

      wait_idle();
      repeat (20) @(negedge clock);
      end_check <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: k_way_sorted_run_merge_core.f
sv/kwm_pkg.sv
sv/kwm_channels.sv
sv/kwm_head_scan.sv
sv/k_way_sorted_run_merge_core.sv
dv/merge_checker.sv
dv/testbench.sv
